// ===== rtl/dmmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_pkg
// shared types, constants and helpers of the diamond mean blur block
// ----------------------------------------------------------------------------
package dmmb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 3;

  localparam int PIX_W      = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int RAD_W      = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 16'd1024;
  localparam logic [RAD_W-1:0]   RADIUS_RST = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_reg_e;

  // per-item classification made by the front end
  typedef struct packed {
    logic emit;
    logic last;
  } dmmb_flags_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_ROW  = 6'b000100,
    ST_TOT  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_OUT  = 6'b100000
  } back_state_e;

  // window position inside the diamond around centre (c, c)
  function automatic logic in_diamond(input int dy, input int dx, input int c, input int r);
    int ady;
    int adx;
    ady = (dy > c) ? dy - c : c - dy;
    adx = (dx > c) ? dx - c : c - dx;
    return (ady + adx) <= r;
  endfunction

endpackage

// ===== rtl/dmmb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dmmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dmmb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_queue
// two-entry queue between front end and back end
// ----------------------------------------------------------------------------
module dmmb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dmmb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_front
// raster position tracking and per-pixel classification
// ----------------------------------------------------------------------------
module dmmb_front #(
  parameter int MAX_WIDTH  = dmmb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = dmmb_pkg::MAX_RADIUS_DEF,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int LINES = 2 * MAX_RADIUS,
  localparam int SW    = $clog2(LINES)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [dmmb_pkg::IMG_W_W-1:0]      cfg_width_i,
  input  logic [dmmb_pkg::IMG_H_W-1:0]      cfg_height_i,
  input  logic [dmmb_pkg::RAD_W-1:0]        radius_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dmmb_pkg::PIX_W-1:0]        pixel_i,
  input  logic                              frame_start_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [dmmb_pkg::PIX_W-1:0]        push_pixel_o,
  output logic [CW-1:0]                     push_col_o,
  output logic [SW-1:0]                     push_slot_o,
  output dmmb_pkg::dmmb_flags_t             push_flags_o
);

  localparam int WW = (dmmb_pkg::IMG_W_W > $clog2(MAX_WIDTH + 1)) ?
                      dmmb_pkg::IMG_W_W : $clog2(MAX_WIDTH + 1);
  localparam int HW = dmmb_pkg::IMG_H_W;

  logic [CW-1:0] col_q, col_d, col;
  logic [HW-1:0] row_q, row_d, row;
  logic [SW-1:0] slot_q, slot_d, slot;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [2:0]    two_r;
  logic          col_wrap, row_wrap, accept;

  always_comb begin
    if (cfg_width_i == '0) begin
      w_eff = WW'(1);
    end else if (WW'(cfg_width_i) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_i);
    end
    h_eff = (cfg_height_i == '0) ? HW'(1) : cfg_height_i;
  end

  assign two_r  = {radius_i, 1'b0};
  assign accept = in_valid_i && push_ready_i;

  // frame start restarts the position for this very pixel
  assign col  = frame_start_i ? '0 : col_q;
  assign row  = frame_start_i ? '0 : row_q;
  assign slot = frame_start_i ? '0 : slot_q;

  assign col_wrap = ((WW + 1)'(col) + (WW + 1)'(1)) >= {1'b0, w_eff};
  assign row_wrap = ((HW + 1)'(row) + (HW + 1)'(1)) >= {1'b0, h_eff};

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row + HW'(1);
          slot_d = (slot == SW'(LINES - 1)) ? '0 : slot + SW'(1);
        end
      end else begin
        col_d  = col + CW'(1);
        row_d  = row;
        slot_d = slot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  assign in_ready_o        = push_ready_i;
  assign push_valid_o      = in_valid_i;
  assign push_pixel_o      = pixel_i;
  assign push_col_o        = col;
  assign push_slot_o       = slot;
  assign push_flags_o.emit = (WW'(col) < w_eff) && (row < h_eff) &&
                             (col >= CW'(two_r)) && (row >= HW'(two_r));
  assign push_flags_o.last = (row == h_eff - HW'(1)) && (WW'(col) == w_eff - WW'(1));

endmodule

// ===== rtl/dmmb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_back
// line store, window shift register, diamond sum and reciprocal divide
// ----------------------------------------------------------------------------
module dmmb_back #(
  parameter int MAX_WIDTH  = dmmb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = dmmb_pkg::MAX_RADIUS_DEF,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int LINES = 2 * MAX_RADIUS,
  localparam int SW    = $clog2(LINES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dmmb_pkg::RAD_W-1:0]    radius_i,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  logic [dmmb_pkg::PIX_W-1:0]    pop_pixel_i,
  input  logic [CW-1:0]                 pop_col_i,
  input  logic [SW-1:0]                 pop_slot_i,
  input  dmmb_pkg::dmmb_flags_t         pop_flags_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dmmb_pkg::PIX_W-1:0]    out_pixel_o,
  output logic                          out_last_o
);

  localparam int PW  = dmmb_pkg::PIX_W;
  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int RSW = PW + $clog2(WIN);
  localparam int TSW = PW + $clog2(WIN * WIN);
  localparam int SH  = 2 * TSW;
  localparam int MW  = SH + 1;
  localparam int NR  = 2 ** dmmb_pkg::RAD_W;

  dmmb_pkg::back_state_e state_q, state_d;

  logic [PW-1:0]         pixel_q;
  logic [CW-1:0]         col_q;
  logic [SW-1:0]         slot_q;
  dmmb_pkg::dmmb_flags_t flags_q;

  logic [PW-1:0]  ram_rdata [LINES];
  logic [PW-1:0]  column [WIN];
  logic [PW-1:0]  win_q [WIN][WIN];
  logic [RSW-1:0] row_sum_q [WIN];
  logic [RSW-1:0] row_sum_d [WIN];
  logic [TSW-1:0] total_q, total_d;
  logic [TSW+MW-1:0] prod_q;
  logic [MW-1:0]  recip [NR];

  logic          out_valid_q;
  logic [PW-1:0] out_pixel_q;
  logic          out_last_q;
  logic          load_out;
  logic [CW-1:0] raddr;

  // reciprocals of the diamond pixel count, exact for every reachable sum
  for (genvar gr = 0; gr < NR; gr++) begin : g_recip
    localparam longint unsigned CNT = 2 * gr * gr + 2 * gr + 1;
    localparam longint unsigned MV  = ((64'd1 << SH) + CNT - 1) / CNT;
    assign recip[gr] = MW'(MV);
  end

  assign raddr = (state_q == dmmb_pkg::ST_IDLE) ? pop_col_i : col_q;

  for (genvar gl = 0; gl < LINES; gl++) begin : g_line
    dmmb_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    ((state_q == dmmb_pkg::ST_RD) && (slot_q == SW'(gl))),
      .waddr_i (col_q),
      .wdata_i (pixel_q),
      .raddr_i (raddr),
      .rdata_o (ram_rdata[gl])
    );
  end

  // new column, oldest row first, newest pixel at the bottom
  always_comb begin
    logic [SW:0] idx;
    for (int j = 0; j < LINES; j++) begin
      idx = (SW + 1)'(slot_q) + (SW + 1)'(j);
      if (idx >= (SW + 1)'(LINES)) begin
        idx = idx - (SW + 1)'(LINES);
      end
      column[j] = ram_rdata[idx[SW-1:0]];
    end
    column[WIN-1] = pixel_q;
  end

  always_comb begin
    for (int dy = 0; dy < WIN; dy++) begin
      row_sum_d[dy] = '0;
      for (int dx = 0; dx < WIN; dx++) begin
        if (dmmb_pkg::in_diamond(dy, dx, WIN - 1 - int'(radius_i), int'(radius_i))) begin
          row_sum_d[dy] = row_sum_d[dy] + RSW'(win_q[dy][dx]);
        end
      end
    end
    total_d = '0;
    for (int dy = 0; dy < WIN; dy++) begin
      total_d = total_d + TSW'(row_sum_q[dy]);
    end
  end

  assign load_out = (state_q == dmmb_pkg::ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      dmmb_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          state_d = dmmb_pkg::ST_RD;
        end
      end
      dmmb_pkg::ST_RD: begin
        state_d = flags_q.emit ? dmmb_pkg::ST_ROW : dmmb_pkg::ST_IDLE;
      end
      dmmb_pkg::ST_ROW: state_d = dmmb_pkg::ST_TOT;
      dmmb_pkg::ST_TOT: state_d = dmmb_pkg::ST_MUL;
      dmmb_pkg::ST_MUL: state_d = dmmb_pkg::ST_OUT;
      dmmb_pkg::ST_OUT: begin
        if (load_out) begin
          state_d = dmmb_pkg::ST_IDLE;
        end
      end
      default: state_d = dmmb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmmb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int dy = 0; dy < WIN; dy++) begin
        for (int dx = 0; dx < WIN; dx++) begin
          win_q[dy][dx] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == dmmb_pkg::ST_RD) begin
        for (int dy = 0; dy < WIN; dy++) begin
          for (int dx = 0; dx < WIN - 1; dx++) begin
            win_q[dy][dx] <= win_q[dy][dx+1];
          end
          win_q[dy][WIN-1] <= column[dy];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pixel_q <= pop_pixel_i;
      col_q   <= pop_col_i;
      slot_q  <= pop_slot_i;
      flags_q <= pop_flags_i;
    end
    if (state_q == dmmb_pkg::ST_ROW) begin
      row_sum_q <= row_sum_d;
    end
    if (state_q == dmmb_pkg::ST_TOT) begin
      total_q <= total_d;
    end
    if (state_q == dmmb_pkg::ST_MUL) begin
      prod_q <= (TSW + MW)'(total_q) * (TSW + MW)'(recip[radius_i]);
    end
    if (load_out) begin
      out_pixel_q <= prod_q[SH +: PW];
      out_last_q  <= flags_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/diamond_mask_mean_blur.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_mask_mean_blur
// truncated mean over a diamond neighbourhood of a raster pixel stream
// ----------------------------------------------------------------------------
// usage
//   s_axis: one 8-bit grey pixel per transfer in raster order, tuser marks
//   the first pixel of a frame and restarts the row and column counters
//   m_axis: one output pixel per window that lies fully inside the frame,
//   tlast on the last output pixel of the frame; no padding
//   cfg: register writes (width, height, radius), taken every cycle; the user
//   must write them only while the block is idle, the block does not enforce it
//   sequencing: the back end sequencer takes one queued pixel at a time and
//   pops the next only once it is back in idle; every pixel passes idle and
//   the line store read with window shift, a pixel with a result then also
//   row sums, total, reciprocal multiply and output load, which waits while
//   the output register holds an unaccepted pixel
//   reset: counters, window and queue cleared, registers to 1024 x 1024,
//   radius 1; the line store is not cleared, no clearing pass
//   stall: the output register holds a finished pixel while the two-entry
//   queue keeps accepting input until it fills
// ----------------------------------------------------------------------------
module diamond_mask_mean_blur #(
  parameter int MAX_WIDTH  = dmmb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = dmmb_pkg::MAX_RADIUS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dmmb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dmmb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel_in
  input  logic                              s_axis_tuser,  // [0] frame_start
  // pixel output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] pixel_out
  output logic                              m_axis_tlast   // frame_last
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int LINES = 2 * MAX_RADIUS;
  localparam int SW    = $clog2(LINES);
  localparam int PW    = dmmb_pkg::PIX_W;
  localparam int QW    = PW + CW + SW + $bits(dmmb_pkg::dmmb_flags_t);

  logic [dmmb_pkg::IMG_W_W-1:0] width_q;
  logic [dmmb_pkg::IMG_H_W-1:0] height_q;
  logic [dmmb_pkg::RAD_W-1:0]   radius_q;
  logic [dmmb_pkg::RAD_W-1:0]   r_eff;

  // front to queue
  logic                  push_valid, push_ready;
  logic [PW-1:0]         push_pixel;
  logic [CW-1:0]         push_col;
  logic [SW-1:0]         push_slot;
  dmmb_pkg::dmmb_flags_t push_flags;
  // queue to back
  logic                  pop_valid, pop;
  logic [QW-1:0]         pop_data;
  logic [PW-1:0]         pop_pixel;
  logic [CW-1:0]         pop_col;
  logic [SW-1:0]         pop_slot;
  dmmb_pkg::dmmb_flags_t pop_flags;

  // configuration registers, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dmmb_pkg::WIDTH_RST;
      height_q <= dmmb_pkg::HEIGHT_RST;
      radius_q <= dmmb_pkg::RADIUS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dmmb_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[dmmb_pkg::IMG_W_W-1:0];
        dmmb_pkg::CFG_HEIGHT: height_q <= cfg_data_i[dmmb_pkg::IMG_H_W-1:0];
        dmmb_pkg::CFG_RADIUS: radius_q <= cfg_data_i[dmmb_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // radius saturates at the largest window built
  assign r_eff = (int'(radius_q) > MAX_RADIUS) ? dmmb_pkg::RAD_W'(MAX_RADIUS) : radius_q;

  dmmb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_width_i   (width_q),
    .cfg_height_i  (height_q),
    .radius_i      (r_eff),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_pixel_o  (push_pixel),
    .push_col_o    (push_col),
    .push_slot_o   (push_slot),
    .push_flags_o  (push_flags)
  );

  dmmb_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_flags, push_slot, push_col, push_pixel}),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  assign {pop_flags, pop_slot, pop_col, pop_pixel} = pop_data;

  dmmb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radius_i    (r_eff),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_pixel_i (pop_pixel),
    .pop_col_i   (pop_col),
    .pop_slot_i  (pop_slot),
    .pop_flags_i (pop_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/dmmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_checker
// port-level checks of the diamond mean blur block
// ----------------------------------------------------------------------------
module dmmb_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // output register is cleared while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // stalled result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

  // no result can leave the pipeline in the first cycles after reset
  a_startup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("output too early after reset");

  // a new result rises only from valid low and only once reset was released
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(m_axis_tvalid) && $past(rst_ni))
    else $error("output without history");

endmodule

bind diamond_mask_mean_blur dmmb_port_checks u_dmmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/dmmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmb_checker
// watches the pixel, output and register channels of the diamond mean blur,
// predicts each output pixel and compares it with the one the block sends
// ----------------------------------------------------------------------------
module dmmb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [7:0]  m_data_i,
  input  logic        m_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import dmmb_pkg::*;

  localparam int MW    = MAX_WIDTH_DEF;
  localparam int MR    = MAX_RADIUS_DEF;
  localparam int WIN   = 2 * MR + 1;
  localparam int LINES = 2 * MR;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } blur_out_t;

  logic [IMG_W_W-1:0] img_width;
  logic [IMG_H_W-1:0] img_height;
  logic [RAD_W-1:0]   rad;
  logic [7:0]         rows_mem [LINES*MW];
  logic [7:0]         win_q [WIN][WIN];
  int                 col_q;
  int                 row_q;
  blur_out_t          blur_expected [$];

  assign pending_o = blur_expected.size();

  task automatic predict_pixel(input logic [7:0] px, input logic fs);
    int w, h, r, col, row, slot, c, sum, cnt;
    logic [7:0] column [WIN];
    blur_out_t  res;
    w = (img_width == 0) ? 1 : ((img_width > MW) ? MW : img_width);
    h = (img_height == 0) ? 1 : img_height;
    r = (rad > MR) ? MR : rad;
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    col = col_q;
    row = row_q;
    if (col < MW) begin
      for (int k = 1; k <= LINES; k++) begin
        slot = (row + LINES - k) % LINES;
        column[LINES-k] = rows_mem[slot*MW + col];
      end
      rows_mem[(row % LINES)*MW + col] = px;
    end else begin
      for (int k = 0; k < WIN; k++) column[k] = '0;
    end
    column[WIN-1] = px;
    for (int dy = 0; dy < WIN; dy++) begin
      for (int dx = 0; dx + 1 < WIN; dx++) win_q[dy][dx] = win_q[dy][dx+1];
      win_q[dy][WIN-1] = column[dy];
    end
    if (col < w && row < h && col >= 2*r && row >= 2*r) begin
      c   = WIN - 1 - r;
      sum = 0;
      cnt = 2*r*r + 2*r + 1;
      for (int dy = c - r; dy <= c + r; dy++)
        for (int dx = c - r; dx <= c + r; dx++)
          if (((dy > c) ? dy - c : c - dy) + ((dx > c) ? dx - c : c - dx) <= r)
            sum += win_q[dy][dx];
      res.pix  = 8'(sum / cnt);
      res.last = (row == h - 1) && (col == w - 1);
      blur_expected.push_back(res);
    end
    if (col + 1 >= w) begin
      col_q = 0;
      row_q = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_q = col + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_out_t exp_px;
    if (!rst_ni) begin
      img_width    <= WIDTH_RST;
      img_height   <= HEIGHT_RST;
      rad          <= RADIUS_RST;
      col_q        = 0;
      row_q        = 0;
      fail_count_o <= 0;
      for (int i = 0; i < LINES*MW; i++) rows_mem[i] = '0;
      for (int y = 0; y < WIN; y++)
        for (int x = 0; x < WIN; x++) win_q[y][x] = '0;
      blur_expected.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_WIDTH:  img_width  <= cfg_data_i[IMG_W_W-1:0];
          CFG_HEIGHT: img_height <= cfg_data_i[IMG_H_W-1:0];
          CFG_RADIUS: rad        <= cfg_data_i[RAD_W-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) predict_pixel(s_data_i, s_user_i);
      if (m_valid_i && m_ready_i) begin
        if (blur_expected.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected output pixel %0d last %0b", m_data_i, m_last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_px = blur_expected.pop_front();
          if (exp_px.pix !== m_data_i || exp_px.last !== m_last_i) begin
            if (fail_count_o < 10)
              $display("output mismatch: expected pixel %0d last %0b, got %0d last %0b",
                       exp_px.pix, exp_px.last, m_data_i, m_last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_diamond_mask_mean_blur.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diamond_mask_mean_blur
// drives frames of random pixels through the diamond mean blur under several
// register settings, with bursty input and a stalling output side
// ----------------------------------------------------------------------------
module tb_diamond_mask_mean_blur;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] pixel_in
  logic        s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] pixel_out
  logic        m_axis_tlast;   // frame_last
  int          fail_count;
  int          pending;
  int          hold_off;       // long receiver stall, in cycles
  int          stall_mode;

  diamond_mask_mean_blur i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  dmmb_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_data_i(s_axis_tdata), .s_user_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_last_i(m_axis_tlast),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // receiver: switches between free flow, light and heavy stalling; a long
  // hold-off overrides everything so the input queue fills up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
    end else begin
      if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off      <= hold_off - 1;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(3) != 0);
          default: m_axis_tready <= ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  int burst_left;

  // one register write, meant only for while the block is idle; neither the task nor the block enforces it
  task automatic write_reg(input dmmb_pkg::cfg_reg_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // sender: bursts of random length, random gaps in between
  task automatic send_pixel(input logic [7:0] px, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // a whole frame; kind 0 random, 1 all white, 2 all black, 3 checker
  task automatic send_frame(input int w, input int h, input int kind);
    logic [7:0] px;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        case (kind)
          1:       px = 8'hFF;
          2:       px = 8'h00;
          3:       px = ((x + y) % 2) ? 8'hFF : 8'h00;
          default: px = 8'($urandom_range(255));
        endcase
        send_pixel(px, (x == 0) && (y == 0));
      end
  endtask

  // wait for every expected pixel, then a latency margin before rewriting
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_shape(input int w, input int h, input int r);
    write_reg(dmmb_pkg::CFG_WIDTH, 16'(w));
    write_reg(dmmb_pkg::CFG_HEIGHT, 16'(h));
    write_reg(dmmb_pkg::CFG_RADIUS, 16'(r));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int w, h, r;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    hold_off      = 0;
    burst_left    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: radius zero pass-through, white and black extremes,
    // frame too small for the window
    set_shape(4, 2, 0);
    send_frame(4, 2, 0);
    drain();
    set_shape(3, 3, 1);
    send_frame(3, 3, 1);
    send_frame(3, 3, 2);
    drain();
    set_shape(2, 2, 1);
    send_frame(2, 2, 0);
    drain();

    // long receiver hold-off while the sender keeps offering pixels; most
    // pixels of this frame produce a result so the block backs up
    set_shape(7, 7, 1);
    hold_off = 200;
    send_frame(7, 7, 3);
    drain();

    // random frames, the tallest setting appears once as a partial frame
    for (int f = 0; f < 8; f++) begin
      r = $urandom_range(3);
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      if (f == 5) begin
        w = 7;
        h = 65535;
        set_shape(w, h, r);
        send_frame(w, 8, 0);  // partial frame, then restart
        drain();
        h = 7;
      end
      set_shape(w, h, r);
      send_frame(w, h, $urandom_range(3) == 0 ? 3 : 0);
      if ($urandom_range(1)) send_frame(w, h, 0);
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
